[rtl/core/array_list_insert_delete_find_core_assert.svh]
// Assertion shorthands for the array list core; clk and rst_n come from the including module.
`ifndef ARRAY_LIST_INSERT_DELETE_FIND_CORE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_FIND_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ALIST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ALIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/alist_pkg.sv]
`default_nettype none

package alist_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int FOUND_W  = 4;
    localparam int COUNT_W  = 5;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_ILLEGAL = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ram_wr_t;

endpackage

`default_nettype wire

[rtl/core/alist_ram.sv]
`default_nettype none

module alist_ram
(
    input  wire logic                        clk,
    input  wire alist_pkg::ram_wr_t          wr,
    input  wire logic [alist_pkg::IDX_W-1:0] rd_addr,
    output logic      [alist_pkg::DATA_W-1:0] rd_data
);

    logic [alist_pkg::DATA_W-1:0] mem [alist_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/array_list_insert_delete_find_core.sv]
`default_nettype none

// Bounded ordered list of up to 16 signed 32-bit entries held in one synchronous RAM
// (one write and one read port, registered read). Each request is find, insert at a
// position or delete at a position and yields one result with status, found position and
// entry count. Requests are handled one at a time: the RAM port walks the affected entries
// one per cycle, at most count entries for find, count - position for insert and
// count - position - 1 for delete; rejected requests and the unused opcode skip the walk.
// The core is ready for the next request in the same cycle that the result appears.
// The result sits in an output register, so a new request is accepted while the previous
// result waits. Reset empties the list at once.
module array_list_insert_delete_find_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] opcode, [33:2] value, [38:34] position, [39] zero
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [5:2] found_position, [10:6] entry_count, [15:11] zero
    output logic      [15:0] m_axis_tdata
);

    localparam int IDX_W  = alist_pkg::IDX_W;
    localparam int CNT_W  = alist_pkg::CNT_W;
    localparam int DATA_W = alist_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         left_reg, left_next;
    logic                     pend_reg, pend_next;
    logic                     m_valid_reg, m_valid_next;

    logic [IDX_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]         pend_ptr_reg, pend_ptr_next;
    logic                     up_reg, up_next;
    logic [1:0]               op_reg, op_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    alist_pkg::status_t       res_status_reg, res_status_next;
    logic [IDX_W-1:0]         res_found_reg, res_found_next;
    logic [15:0]              m_data_reg, m_data_next;

    alist_pkg::ram_wr_t       ram_wr;
    logic [IDX_W-1:0]         ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;

    logic                     in_fire;
    logic                     issue;
    logic                     out_free;
    logic [1:0]               in_op;
    logic signed [DATA_W-1:0] in_value;
    logic [alist_pkg::POS_W-1:0] in_pos;

    alist_ram u_ram
    (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_op    = s_axis_tdata[1:0];
    assign in_value = s_axis_tdata[33:2];
    assign in_pos   = s_axis_tdata[38:34];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign issue         = (left_reg != '0);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign ram_rd_addr   = rd_ptr_reg;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        pend_next       = 1'b0;
        m_valid_next    = m_valid_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_ptr_next   = pend_ptr_reg;
        up_next         = up_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        m_data_next     = m_data_reg;
        ram_wr.en       = 1'b0;
        ram_wr.addr     = pend_ptr_reg;
        ram_wr.data     = ram_rd_data;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = in_op;
                    value_next      = in_value;
                    pos_next        = in_pos[IDX_W-1:0];
                    res_status_next = alist_pkg::STAT_OK;
                    res_found_next  = '0;
                    rd_ptr_next     = IDX_W'(count_reg - CNT_W'(1));
                    up_next         = 1'b0;
                    state_next      = ST_EMIT;
                    case (in_op)
                        alist_pkg::OP_FIND:
                        begin
                            left_next  = count_reg;
                            state_next = ST_WALK;
                        end
                        alist_pkg::OP_INSERT:
                        begin
                            if (count_reg >= alist_pkg::CAP_CNT)
                            begin
                                res_status_next = alist_pkg::STAT_FULL;
                            end
                            else if (32'(in_pos) > 32'(count_reg))
                            begin
                                res_status_next = alist_pkg::STAT_ILLEGAL;
                            end
                            else
                            begin
                                // shift from the top entry down to the position
                                left_next  = count_reg - CNT_W'(in_pos);
                                state_next = ST_WALK;
                            end
                        end
                        alist_pkg::OP_DELETE:
                        begin
                            if (32'(in_pos) >= 32'(count_reg))
                            begin
                                res_status_next = alist_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // pull entries above the position down by one
                                left_next   = count_reg - CNT_W'(in_pos) - CNT_W'(1);
                                rd_ptr_next = IDX_W'(in_pos) + IDX_W'(1);
                                up_next     = 1'b1;
                                state_next  = ST_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (issue)
                begin
                    rd_ptr_next   = up_reg ? rd_ptr_reg + IDX_W'(1) : rd_ptr_reg - IDX_W'(1);
                    left_next     = left_reg - CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_ptr_next = rd_ptr_reg;
                end

                case (op_reg)
                    alist_pkg::OP_FIND:
                    begin
                        if (pend_reg && (ram_rd_data == $unsigned(value_reg)))
                        begin
                            res_found_next = pend_ptr_reg;
                            pend_next      = 1'b0;
                            state_next     = ST_EMIT;
                        end
                        else if (!issue)
                        begin
                            res_status_next = alist_pkg::STAT_EMPTY;
                            pend_next       = 1'b0;
                            state_next      = ST_EMIT;
                        end
                    end
                    alist_pkg::OP_INSERT:
                    begin
                        if (pend_reg)
                        begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = pend_ptr_reg + IDX_W'(1);
                        end
                        else if (!issue)
                        begin
                            // slot is open: drop the new value in
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = pos_reg;
                            ram_wr.data = value_reg;
                            count_next  = count_reg + CNT_W'(1);
                            state_next  = ST_EMIT;
                        end
                    end
                    alist_pkg::OP_DELETE:
                    begin
                        if (pend_reg)
                        begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = pend_ptr_reg - IDX_W'(1);
                        end
                        if (!issue)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = ST_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0,
                                    alist_pkg::COUNT_W'(count_reg),
                                    alist_pkg::FOUND_W'(res_found_reg),
                                    res_status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        pend_ptr_reg   <= pend_ptr_next;
        up_reg         <= up_next;
        op_reg         <= op_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        m_data_reg     <= m_data_next;
    end

`include "array_list_insert_delete_find_core_assert.svh"

    `ALIST_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= alist_pkg::CAP_CNT, "count above capacity")
    `ALIST_ASSERT_SAME(a_write_in_walk, ram_wr.en, state_reg == ST_WALK, "RAM write outside walk")
    `ALIST_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "ready right after accept")
    `ALIST_ASSERT_NEXT(a_result_after_emit, (state_reg == ST_EMIT) && out_free, m_axis_tvalid, "result lost")

endmodule

`default_nettype wire

[sim/list_checker.sv]
`timescale 1ns / 100ps

module list_checker
    import alist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [1:0] opcode, [33:2] value, [38:34] position, [39] zero
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [5:2] found_position, [10:6] entry_count, [15:11] zero
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        status_t             status;
        logic [FOUND_W-1:0]  found;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len;
    list_result_t      results_due [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task report_mismatch(input string what, input int want_v, input int got_v);
        $display("%0t ns list result: %s expected %0d got %0d", $time, what, want_v, got_v);
        fail_count++;
    endtask

    // Apply one request to the shadow list and work out the result it must give.
    task apply_list_op(input op_t op, input logic [DATA_W-1:0] val, input int pos,
                       output list_result_t res);
        int   i;
        logic hit;
        res.status = STAT_OK;
        res.found  = '0;
        hit        = 1'b0;
        case (op)
            OP_FIND:
            begin
                // search from the top so the highest matching slot wins
                for (i = list_len - 1; i >= 0 && !hit; i--)
                begin
                    if (list_mem[i] == val)
                    begin
                        hit       = 1'b1;
                        res.found = i[FOUND_W-1:0];
                    end
                end
                if (!hit)
                    res.status = STAT_EMPTY;
            end
            OP_INSERT:
            begin
                // fullness is checked before the position
                if (list_len >= CAPACITY)
                    res.status = STAT_FULL;
                else if (pos > list_len)
                    res.status = STAT_ILLEGAL;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= list_len)
                    res.status = STAT_EMPTY;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        res.count = list_len[COUNT_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t fresh;
        if (!rst_n)
        begin
            list_len = 0;
            results_due.delete();
            pending <= 0;
        end
        else
        begin
            // a result can never belong to a request taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result with no request pending", 0, int'(m_tdata));
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", want.status, m_tdata[1:0]);
                    if (m_tdata[5:2] !== want.found)
                        report_mismatch("found_position", want.found, m_tdata[5:2]);
                    if (m_tdata[10:6] !== want.count)
                        report_mismatch("entry_count", want.count, m_tdata[10:6]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_list_op(op_t'(s_tdata[1:0]), s_tdata[33:2], int'(s_tdata[38:34]), fresh);
                results_due.push_back(fresh);
            end
            pending <= results_due.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import alist_pkg::*;

    localparam int RANDOM_ITEMS     = 1425;
    localparam int IDLE_PCT         = 31;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int PHASE_LEN        = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int hold_requests = 0;
    int holds_taken = 0;
    logic quiet_phase = 1'b0;

    logic [DATA_W-1:0] value_pool [8];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    array_list_insert_delete_find_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    list_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result sink: random back-pressure, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_taken != hold_requests)
            begin
                holds_taken++;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_request(input op_t op, input logic [DATA_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        if (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {1'b0, pos, val, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Hold the request side until every result is back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 60)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial
    begin
        int   k;
        int   roll;
        logic growing;
        op_t  op;
        logic [POS_W-1:0] pos;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom_range(0, 20) - 10;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: miss, empty slot, insert past the end
        send_request(OP_FIND, 32'h0000_0000, 5'd0);
        send_request(OP_DELETE, 32'h0000_0000, 5'd0);
        send_request(OP_INSERT, 32'h1234_5678, 5'd1);
        // extremes, append and shift up
        send_request(OP_INSERT, 32'h8000_0000, 5'd0);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 5'd1);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
        send_request(OP_FIND, 32'hFFFF_FFFF, 5'd31);
        send_request(OP_FIND, 32'h8000_0000, 5'd0);
        send_request(OP_FIND, 32'h0000_0000, 5'd0);
        // duplicate: find must report the higher slot
        send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd3);
        send_request(OP_FIND, 32'hFFFF_FFFF, 5'd0);
        send_request(OP_INSERT, 32'h0000_0001, 5'd31);
        for (k = 0; k < 12; k++)
            send_request(OP_INSERT, $urandom, k[POS_W-1:0]);
        // full list wins over a bad position
        send_request(OP_INSERT, 32'h0000_0002, 5'd31);
        send_request(OP_INSERT, 32'h0000_0002, 5'd0);
        send_request(OP_DELETE, 32'h0000_0000, 5'd15);
        send_request(OP_DELETE, 32'h0000_0000, 5'd31);
        send_request(OP_DELETE, 32'h0000_0000, 5'd0);

        growing = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % PHASE_LEN == 0)
                growing = ~growing;
            if (k == 300)
                hold_requests <= hold_requests + 1;
            if (k == 700)
                wait_results_drained();
            if (k == 900)
                quiet_phase <= 1'b1;
            if (k == 1100)
                quiet_phase <= 1'b0;

            roll = $urandom_range(0, 99);
            if (growing)
                op = (roll < 55) ? OP_INSERT : (roll < 85) ? OP_FIND : OP_DELETE;
            else
                op = (roll < 20) ? OP_INSERT : (roll < 50) ? OP_FIND : OP_DELETE;

            // lean toward low positions so most inserts and deletes land
            if ($urandom_range(0, 99) < 88)
                pos = POS_W'($urandom_range(0, $urandom_range(0, 16)));
            else
                pos = POS_W'($urandom_range(17, 31));

            send_request(op, pick_value(), pos);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
